### rtl/core/spq_pkg.sv
// Package for the sorted priority queue: request and response types,
// operation and status codes, and the store size. No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] item_value;
		logic        [7:0]  item_priority;
	} spq_req_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic        [7:0]  out_priority;
		logic        [1:0]  status;
		logic        [4:0]  occupancy;
	} spq_rsp_t;

	typedef struct packed {
		logic               enq;
		logic signed [31:0] value;
		logic        [7:0]  pri;
		logic [CNT_W-1:0]   count;
	} spq_bcast_t;

endpackage

### rtl/core/spq_cell.sv
// One slot of the sorted store. It compares its priority with the incoming
// one and, on an enqueue, loads its upper neighbor, the new entry or neither. Uses spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
	input  logic                      clk,
	input  logic [spq_pkg::CNT_W-1:0] idx,
	input  spq_pkg::spq_bcast_t       bcast,
	input  logic                      prev_lt,
	input  logic signed [31:0]        prev_value,
	input  logic        [7:0]         prev_pri,
	output logic                      lt,
	output logic signed [31:0]        value,
	output logic        [7:0]         pri
);
	import spq_pkg::*;

	logic signed [31:0] value_q;
	logic        [7:0]  pri_q;
	logic               occ;
	logic               at_end;

	assign occ    = idx < bcast.count;
	assign at_end = idx == bcast.count;
	assign lt     = occ && (pri_q < bcast.pri);
	assign value  = value_q;
	assign pri    = pri_q;

	always_ff @(posedge clk) begin
		if (bcast.enq) begin
			if (prev_lt) begin
				value_q <= prev_value;
				pri_q   <= prev_pri;
			end else if (lt || at_end) begin
				value_q <= bcast.value;
				pri_q   <= bcast.pri;
			end
		end
	end

endmodule

### rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: the chain of store cells, the
// entry count and the response register. Uses spq_pkg and spq_cell.
`timescale 1ns / 1ps

// One request is taken per clock cycle, and its response appears in the
// response register on the next cycle; a new request is taken while that
// response waits, as long as the register is freed in the same cycle. Every
// cell of the chain compares its priority with the incoming one at once, so
// an enqueue shifts the lower entries down together, and a dequeue
// reads the tail cell selected by the entry count. Rejected requests leave
// the store unchanged.
module sorted_priority_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  spq_pkg::spq_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output spq_pkg::spq_rsp_t rsp
);
	import spq_pkg::*;

	logic [CNT_W-1:0]   count_q;
	logic               rsp_valid_q;
	spq_rsp_t           rsp_q;
	spq_rsp_t           rsp_d;
	logic [CNT_W-1:0]   count_d;
	logic               accept;
	logic               full;
	logic               empty;
	logic [CNT_W-1:0]   tail;
	spq_bcast_t         bcast;
	logic               lt_w    [DEPTH];
	logic signed [31:0] value_w [DEPTH];
	logic        [7:0]  pri_w   [DEPTH];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = count_q == CNT_W'(DEPTH);
	assign empty     = count_q == '0;
	assign tail      = count_q - CNT_W'(1);

	assign bcast.enq   = accept && (req.kind == OP_ENQ) && !full;
	assign bcast.value = req.item_value;
	assign bcast.pri   = req.item_priority;
	assign bcast.count = count_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			spq_cell u_cell (
				.clk        (clk),
				.idx        (CNT_W'(i)),
				.bcast      (bcast),
				.prev_lt    (1'b0),
				.prev_value (32'sd0),
				.prev_pri   (8'd0),
				.lt         (lt_w[i]),
				.value      (value_w[i]),
				.pri        (pri_w[i])
			);
		end else begin : g_body
			spq_cell u_cell (
				.clk        (clk),
				.idx        (CNT_W'(i)),
				.bcast      (bcast),
				.prev_lt    (lt_w[i-1]),
				.prev_value (value_w[i-1]),
				.prev_pri   (pri_w[i-1]),
				.lt         (lt_w[i]),
				.value      (value_w[i]),
				.pri        (pri_w[i])
			);
		end
	end

	always_comb begin
		rsp_d   = '0;
		count_d = count_q;
		if (req.kind == OP_ENQ) begin
			if (full) begin
				rsp_d.status = STAT_FULL;
			end else begin
				rsp_d.status = STAT_DONE;
				count_d      = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				rsp_d.status = STAT_EMPTY;
			end else begin
				rsp_d.status       = STAT_DONE;
				rsp_d.out_value    = value_w[tail[IDX_W-1:0]];
				rsp_d.out_priority = pri_w[tail[IDX_W-1:0]];
				count_d            = tail;
			end
		end
		rsp_d.occupancy = 5'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to its top level.
// Uses spq_pkg.
`timescale 1ns / 1ps

module spq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input spq_pkg::spq_rsp_t rsp
);
	import spq_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed before it was taken");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STAT_EMPTY) |-> rsp.occupancy == 5'd0)
		else $error("empty rejection with nonzero occupancy");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STAT_FULL) |-> rsp.occupancy == 5'(DEPTH))
		else $error("full rejection without a full store");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STAT_DONE)
		|-> rsp.out_value == 32'sd0 && rsp.out_priority == 8'd0)
		else $error("rejected request returned data");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.occupancy <= 5'(DEPTH) && rsp.status <= STAT_EMPTY)
		else $error("occupancy or status out of range");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

### verif/testbench.sv
// Self-checking testbench for sorted_priority_queue: directed and random requests,
// a sorted-store predictor, random idling on both sides. Depends on spq_pkg.
`timescale 1ns / 1ps

module testbench;
	import spq_pkg::*;

	localparam int RANDOM_REQS = 1600;
	localparam int QUIET_TAIL  = 150;

	typedef struct {
		spq_req_t req;
		bit       hold;
	} stim_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	spq_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	spq_rsp_t rsp;

	stim_t    req_backlog[$];
	spq_rsp_t awaited_rsp[$];

	logic signed [31:0] store_value [DEPTH];
	logic        [7:0]  store_pri [DEPTH];
	int                 store_count = 0;

	logic req_taken = 1'b0;
	int   errors = 0;
	int   sent_count = 0;
	int   req_gap = 0;
	int   req_gap_pct = 0;
	int   rsp_gap = 0;
	int   rsp_gap_pct = 0;
	int   cycle_count = 0;

	sorted_priority_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic spq_rsp_t queue_apply(input spq_req_t r);
		spq_rsp_t res;
		int       pos;
		res = '0;
		res.status = STAT_DONE;
		if (r.kind == OP_ENQ) begin
			if (store_count >= DEPTH) begin
				res.status = STAT_FULL;
			end else begin
				pos = store_count;
				while (pos > 0 && store_pri[pos - 1] < r.item_priority) begin
					store_value[pos] = store_value[pos - 1];
					store_pri[pos] = store_pri[pos - 1];
					pos--;
				end
				store_value[pos] = r.item_value;
				store_pri[pos] = r.item_priority;
				store_count++;
			end
		end else begin
			if (store_count == 0) begin
				res.status = STAT_EMPTY;
			end else begin
				store_count--;
				res.out_value = store_value[store_count];
				res.out_priority = store_pri[store_count];
			end
		end
		res.occupancy = store_count[4:0];
		return res;
	endfunction

	task automatic add_req(input logic kind, input logic signed [31:0] value,
			input logic [7:0] pri, input bit hold);
		stim_t s;
		s.req.kind = kind;
		s.req.item_value = value;
		s.req.item_priority = pri;
		s.hold = hold;
		req_backlog.push_back(s);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : observe
		spq_rsp_t want;
		if (arst_n) begin
			req_taken <= req_valid && req_ready;
			cycle_count++;
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					$display("%0t ns: unexpected response, expected none, got %h", $time, rsp);
					errors++;
				end else begin
					want = awaited_rsp.pop_front();
					check_field("out_value", want.out_value, rsp.out_value);
					check_field("out_priority", 32'(want.out_priority), 32'(rsp.out_priority));
					check_field("status", 32'(want.status), 32'(rsp.status));
					check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
				end
			end
			if (req_valid && req_ready)
				awaited_rsp.push_back(queue_apply(req));
		end
	end

	always @(negedge clk) begin : drive_req
		stim_t head;
		if (arst_n && (!req_valid || req_taken)) begin
			if (req_gap > 0) begin
				req_valid <= 1'b0;
				req_gap--;
			end else if (req_backlog.size() == 0 ||
					(req_backlog[0].hold && awaited_rsp.size() != 0)) begin
				req_valid <= 1'b0;
			end else begin
				head = req_backlog.pop_front();
				req <= head.req;
				req_valid <= 1'b1;
				sent_count++;
				if (sent_count % 100 == 0)
					req_gap_pct = $urandom_range(2) * 15;
				if (req_backlog.size() > QUIET_TAIL && $urandom_range(99) < req_gap_pct)
					req_gap = $urandom_range(1, 11);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (cycle_count % 128 == 0)
				rsp_gap_pct = $urandom_range(2) * 5;
			if (rsp_gap > 0) begin
				rsp_ready <= 1'b0;
				rsp_gap--;
			end else if (req_backlog.size() > QUIET_TAIL && $urandom_range(99) < rsp_gap_pct) begin
				rsp_ready <= 1'b0;
				rsp_gap = $urandom_range(0, 10);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("sorted_priority_queue verification failed");
		$finish;
	end

	initial begin : stimulus
		int enq_pct;
		int pri_mode;
		logic [7:0] pri;

		add_req(OP_DEQ, -32'sd1, 8'hff, 1'b0);
		add_req(OP_ENQ, 32'sh7fffffff, 8'd255, 1'b0);
		add_req(OP_ENQ, 32'sh80000000, 8'd0, 1'b0);
		add_req(OP_ENQ, 32'sd0, 8'd128, 1'b0);
		add_req(OP_ENQ, -32'sd1, 8'd255, 1'b0);
		add_req(OP_ENQ, 32'sd1, 8'd0, 1'b0);
		for (int k = 0; k < 11; k++)
			add_req(OP_ENQ, $urandom, (k % 4 == 0) ? 8'd128 : 8'(k * 53), 1'b0);
		add_req(OP_ENQ, 32'sh55555555, 8'd0, 1'b0);
		add_req(OP_ENQ, 32'shaaaaaaaa, 8'd255, 1'b0);
		for (int k = 0; k < 4; k++)
			add_req(OP_DEQ, $urandom, 8'($urandom), 1'b0);

		enq_pct = 50;
		pri_mode = 0;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(3))
					0: enq_pct = 15;
					1: enq_pct = 85;
					2: enq_pct = 50;
					default: enq_pct = $urandom_range(100);
				endcase
				pri_mode = $urandom_range(2);
			end
			case (pri_mode)
				0: pri = 8'($urandom_range(3));
				1: pri = $urandom_range(1) ? 8'd255 : 8'd0;
				default: pri = 8'($urandom_range(255));
			endcase
			add_req(($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ, $urandom, pri,
				(n % 400 == 399));
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || req_valid)
			@(posedge clk);
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0) begin
			$display("sorted_priority_queue verification clean");
		end else begin
			$display("sorted_priority_queue verification failed");
		end
		$finish;
	end

endmodule

### sorted_priority_queue.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
rtl/core/spq_checker.sv
verif/testbench.sv
